// ----- src/bec_pkg.sv -----
`timescale 1ns / 1ps
// Package for the backslash escape codec: payload structs, character codes,
// register indexes and the escape / unescape mapping functions. No dependencies.
package bec_pkg;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LTR_N  = 8'h6E;
    localparam logic [7:0] CH_LTR_C  = 8'h63;
    localparam logic [7:0] CH_LTR_Z  = 8'h7A;
    localparam logic [7:0] CH_LTR_Y  = 8'h79;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 1'd1;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic DIR_ESCAPE   = 1'b0;
    localparam logic DIR_UNESCAPE = 1'b1;

    localparam logic [15:0] OUT_LIMIT_RESET = 16'hFFFF;

    // Depth of the command queue between front and back; a power of two.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       truncated;
    } t_out;

    // One classified item: up to two characters, then optionally an end result.
    typedef struct packed {
        logic [1:0] nbytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       eos;
        logic       trunc;
    } t_cmd;

    // Escape letter for a special byte, zero when the byte is not special.
    function automatic logic [7:0] esc_code(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            CH_NL:     r = CH_LTR_N;
            CH_COMMA:  r = CH_LTR_C;
            CH_BAR:    r = CH_LTR_Z;
            CH_BSLASH: r = CH_LTR_Y;
            default:   r = CH_NUL;
        endcase
        return r;
    endfunction

    // Original byte for an escape letter; other letters pass through.
    function automatic logic [7:0] unesc_code(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            CH_LTR_N: r = CH_NL;
            CH_LTR_C: r = CH_COMMA;
            CH_LTR_Z: r = CH_BAR;
            CH_LTR_Y: r = CH_BSLASH;
            default:  r = b;
        endcase
        return r;
    endfunction

endpackage

// ----- src/backslash_escape_codec.sv -----
`timescale 1ns / 1ps
// Backslash escape codec, top level. Joins the front, the command queue and
// the back part. Uses bec_pkg, bec_front, bec_queue and bec_back.
//
// Input bytes are offered on i_data with push and taken when full is low.
// Results leave as a queue: while empty is low, o_result holds the oldest
// result, and pop takes it. The configuration port (i_cfg_we, i_cfg_idx,
// i_cfg_data) writes direction (index 0) or out_limit (index 1);
// write it only while no string is in flight.
// A byte is classified in the cycle it is accepted and queued; its first
// result then passes the command queue, the back part's command register
// and the output register before it appears on o_result. The back part
// delivers one result per cycle while the output register is free: two for
// a byte that becomes an escape pair, one for a plain byte or an end result.
// If the receiver stops popping, the output register, the back part and the
// four-entry command queue fill up, and full then rises; no result is lost.
// Synchronous reset restores direction to escape, out_limit to 65535 and
// clears all string state and queued results.
module backslash_escape_codec import bec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_in                   i_data,
    output logic                  empty,
    input  logic                  pop,
    output t_out                  o_result
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd front_cmd;
    t_cmd head_cmd;

    bec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_data     (i_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_cmd      (front_cmd)
    );

    bec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    assign full = q_full;

endmodule

// ----- src/bec_front.sv -----
`timescale 1ns / 1ps
// Front part of the escape codec: holds the configuration and per-string state,
// accepts input bytes and turns each into a command for the queue. Uses bec_pkg.
module bec_front import bec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  t_in                   i_data,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_cmd
);

    logic        r_direction;
    logic [15:0] r_out_limit;
    logic [15:0] r_written;
    logic        r_stopped;
    logic        r_pending;

    logic [15:0] n_written;
    logic        n_stopped;
    logic        n_pending;
    logic        accept;
    logic [7:0]  code;
    logic [16:0] cnt_p1;
    logic [16:0] cnt_p2;
    logic [16:0] lim_ext;
    t_cmd        cmd;

    assign accept  = i_push && !i_q_full;
    assign code    = esc_code(i_data.data_byte);
    assign cnt_p1  = {1'b0, r_written} + 17'd1;
    assign cnt_p2  = {1'b0, r_written} + 17'd2;
    assign lim_ext = {1'b0, r_out_limit};

    always_comb begin
        n_written = r_written;
        n_stopped = r_stopped;
        n_pending = r_pending;
        cmd.nbytes = 2'd0;
        cmd.b0     = i_data.data_byte;
        cmd.b1     = code;
        cmd.eos    = i_data.is_last;
        cmd.trunc  = 1'b0;

        if (r_direction == DIR_ESCAPE) begin
            if (!r_stopped) begin
                if (cnt_p1 >= lim_ext) begin
                    n_stopped = 1'b1;
                end else if (code != CH_NUL) begin
                    if (cnt_p2 < lim_ext) begin
                        cmd.nbytes = 2'd2;
                        cmd.b0     = CH_BSLASH;
                        n_written  = cnt_p2[15:0];
                    end else begin
                        n_stopped = 1'b1;
                    end
                end else begin
                    cmd.nbytes = 2'd1;
                    n_written  = cnt_p1[15:0];
                end
            end
        end else begin
            if (r_pending) begin
                n_pending  = 1'b0;
                cmd.nbytes = 2'd1;
                cmd.b0     = unesc_code(i_data.data_byte);
            end else if (i_data.data_byte == CH_BSLASH) begin
                n_pending = 1'b1;
            end else begin
                cmd.nbytes = 2'd1;
            end
        end

        // The end result reports truncation as it stands after this byte.
        if (i_data.is_last) begin
            cmd.trunc = n_stopped;
            n_written = 16'd0;
            n_stopped = 1'b0;
            n_pending = 1'b0;
        end
    end

    // Items that produce no result at all are not queued.
    assign o_q_push = accept && ((cmd.nbytes != 2'd0) || cmd.eos);
    assign o_cmd    = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ESCAPE;
            r_out_limit <= OUT_LIMIT_RESET;
            r_written   <= 16'd0;
            r_stopped   <= 1'b0;
            r_pending   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DIRECTION: r_direction <= i_cfg_data[0];
                    REG_OUT_LIMIT: r_out_limit <= i_cfg_data[15:0];
                    default:       r_direction <= r_direction;
                endcase
            end
            if (accept) begin
                r_written <= n_written;
                r_stopped <= n_stopped;
                r_pending <= n_pending;
            end
        end
    end

endmodule

// ----- src/bec_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back parts of the escape codec.
// Uses bec_pkg for the command type and depth.
module bec_queue import bec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr;
    logic              rd;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- src/bec_back.sv -----
`timescale 1ns / 1ps
// Back part of the escape codec: expands queued commands into single results
// and holds them in the output register. Uses bec_pkg.
module bec_back import bec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_q_empty,
    output logic o_q_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_result
);

    t_cmd       r_cmd;
    logic       r_cmd_valid;
    logic [1:0] r_step;
    t_out       r_out;
    logic       r_out_valid;

    logic       out_free;
    logic       take;
    logic       last_res;
    logic       cmd_load;
    logic [1:0] total;
    t_out       cur;

    assign total    = r_cmd.nbytes + {1'b0, r_cmd.eos};
    assign last_res = (r_step == total - 2'd1);
    assign out_free = !r_out_valid || i_pop;
    assign take     = r_cmd_valid && out_free;
    assign cmd_load = !i_q_empty && (!r_cmd_valid || (take && last_res));
    assign o_q_pop  = cmd_load;

    always_comb begin
        if (r_step < r_cmd.nbytes) begin
            cur.out_byte      = (r_step == 2'd0) ? r_cmd.b0 : r_cmd.b1;
            cur.byte_valid    = 1'b1;
            cur.end_of_string = 1'b0;
            cur.truncated     = 1'b0;
        end else begin
            cur.out_byte      = CH_NUL;
            cur.byte_valid    = 1'b0;
            cur.end_of_string = 1'b1;
            cur.truncated     = r_cmd.trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= cur;
        end
        if (cmd_load) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end

            if (cmd_load) begin
                r_cmd_valid <= 1'b1;
                r_step      <= 2'd0;
            end else if (take && last_res) begin
                r_cmd_valid <= 1'b0;
                r_step      <= 2'd0;
            end else if (take) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ----- bench/backslash_escape_codec_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for backslash_escape_codec: directed strings, then random ones.
// It predicts every result in both modes. Depends on bec_pkg and the codec RTL.
module backslash_escape_codec_tb;
    import bec_pkg::*;

    localparam int RANDOM_ITEMS  = 320;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  full;
    t_in                   i_data     = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_out                  o_result;

    backslash_escape_codec u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_data     (i_data),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Codec state as the bench sees it.
    logic        mdl_dir         = DIR_ESCAPE;
    logic [15:0] mdl_limit       = OUT_LIMIT_RESET;
    logic [15:0] mdl_count       = '0;
    logic        mdl_stopped     = 1'b0;
    logic        mdl_esc_pending = 1'b0;

    t_in  pending_bytes[$];
    t_out expected_results[$];

    int in_mode  = 1;
    int out_mode = 1;
    int gap_left  = 0;
    int hold_left = 0;

    int fail_count      = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int strings_closed  = 0;
    int strings_trunc   = 0;
    int cycle_count     = 0;

    function automatic logic [7:0] escape_letter(input logic [7:0] b);
        case (b)
            CH_NL:     return CH_LTR_N;
            CH_COMMA:  return CH_LTR_C;
            CH_BAR:    return CH_LTR_Z;
            CH_BSLASH: return CH_LTR_Y;
            default:   return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] restore_byte(input logic [7:0] b);
        case (b)
            CH_LTR_N: return CH_NL;
            CH_LTR_C: return CH_COMMA;
            CH_LTR_Z: return CH_BAR;
            CH_LTR_Y: return CH_BSLASH;
            default:  return b;
        endcase
    endfunction

    // Mode 0 never idles, mode 1 may idle after every request, mode 2 only now and then.
    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 16);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
        endcase
    endfunction

    task automatic expect_result(input logic [7:0] b, input logic valid, input logic eos,
                                 input logic trunc);
        t_out r;
        r.out_byte      = b;
        r.byte_valid    = valid;
        r.end_of_string = eos;
        r.truncated     = trunc;
        expected_results.push_back(r);
    endtask

    task automatic predict_codec(input t_in item);
        logic [7:0] code;
        code = escape_letter(item.data_byte);
        if (mdl_dir == DIR_ESCAPE) begin
            if (!mdl_stopped) begin
                if (int'(mdl_count) + 1 >= int'(mdl_limit)) begin
                    mdl_stopped = 1'b1;
                end else if (code != CH_NUL) begin
                    // The pair is written whole or not at all.
                    if (int'(mdl_count) + 2 < int'(mdl_limit)) begin
                        expect_result(CH_BSLASH, 1'b1, 1'b0, 1'b0);
                        expect_result(code, 1'b1, 1'b0, 1'b0);
                        mdl_count = mdl_count + 16'd2;
                    end else begin
                        mdl_stopped = 1'b1;
                    end
                end else begin
                    expect_result(item.data_byte, 1'b1, 1'b0, 1'b0);
                    mdl_count = mdl_count + 16'd1;
                end
            end
        end else begin
            if (mdl_esc_pending) begin
                mdl_esc_pending = 1'b0;
                expect_result(restore_byte(item.data_byte), 1'b1, 1'b0, 1'b0);
            end else if (item.data_byte == CH_BSLASH) begin
                mdl_esc_pending = 1'b1;
            end else begin
                expect_result(item.data_byte, 1'b1, 1'b0, 1'b0);
            end
        end
        if (item.is_last) begin
            expect_result(CH_NUL, 1'b0, 1'b1, mdl_stopped);
            mdl_count       = '0;
            mdl_stopped     = 1'b0;
            mdl_esc_pending = 1'b0;
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected result: byte %02h valid %b eos %b trunc %b",
                         got.out_byte, got.byte_valid, got.end_of_string, got.truncated);
        end else begin
            want = expected_results.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.end_of_string !== want.end_of_string ||
                got.truncated !== want.truncated) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result %0d mismatch: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                             results_checked, want.out_byte, want.byte_valid,
                             want.end_of_string, want.truncated, got.out_byte,
                             got.byte_valid, got.end_of_string, got.truncated);
            end
        end
        results_checked++;
        if (got.end_of_string === 1'b1) begin
            strings_closed++;
            if (got.truncated === 1'b1)
                strings_trunc++;
        end
    endtask

    // Request side: one item on the port at a time, with a drawn gap after each.
    always @(posedge i_clk) begin
        logic next_push;
        t_in  next_item;
        next_push = push;
        next_item = i_data;
        if (i_rst_n) begin
            if (push && !full) begin
                predict_codec(i_data);
                items_accepted++;
                next_push = 1'b0;
            end
            if (!next_push) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() != 0) begin
                    next_item = pending_bytes.pop_front();
                    next_push = 1'b1;
                    gap_left  = draw_gap(in_mode);
                end
            end
        end
        push   <= next_push;
        i_data <= next_item;
    end

    // Result side: pop with a drawn stall after each accepted result.
    always @(posedge i_clk) begin
        logic next_pop;
        next_pop = pop;
        if (i_rst_n) begin
            if (pop && !empty) begin
                check_result(o_result);
                hold_left = draw_gap(out_mode);
                next_pop  = (hold_left == 0);
            end else if (!pop) begin
                if (hold_left > 0)
                    hold_left--;
                else
                    next_pop = 1'b1;
            end
        end
        pop <= next_pop;
    end

    always @(posedge i_clk) begin
        cycle_count++;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("Verification failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        logic [31:0]           noise;
        data  = value;
        noise = $urandom;
        // Only bit 0 of the direction register counts; the rest is noise.
        if (idx == REG_DIRECTION)
            data[CFG_DATA_W-1:1] = noise[CFG_DATA_W-1:1];
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_DIRECTION)
            mdl_dir = data[0];
        else
            mdl_limit = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_in item;
        item.data_byte = b;
        item.is_last   = last;
        pending_bytes.push_back(item);
    endtask

    task automatic queue_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], close && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] pick_byte(input int sel);
        if (sel < 6) begin
            case ($urandom_range(0, 3))
                0:       return CH_NL;
                1:       return CH_COMMA;
                2:       return CH_BAR;
                default: return CH_BSLASH;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 5))
            0:       return CH_LTR_N;
            1:       return CH_LTR_C;
            2:       return CH_LTR_Z;
            3:       return CH_LTR_Y;
            4:       return CH_BSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Unescape strings are mostly well-formed escape pairs; a backslash picked
    // as the final byte gives a trailing lone backslash.
    task automatic queue_random_string(input int len, input logic dir, input logic close);
        int n;
        int sel;
        n = 0;
        while (n < len) begin
            sel = $urandom_range(0, 9);
            if (dir == DIR_UNESCAPE && sel < 4 && n + 1 < len) begin
                queue_byte(CH_BSLASH, 1'b0);
                queue_byte(pick_letter(), close && (n + 2 == len));
                n += 2;
            end else begin
                queue_byte(pick_byte(sel), close && (n + 1 == len));
                n += 1;
            end
        end
    endtask

    task automatic drain_block();
        do
            @(posedge i_clk);
        while (pending_bytes.size() != 0 || push || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          random_items;
        int          queued;
        int          len;
        logic        dir;
        logic        close;
        logic [15:0] limit;
        random_items = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: escape mode with the largest limit.
        queue_text("\n,|\\", 1'b0);
        queue_byte(CH_NUL, 1'b0);
        queue_byte(8'hFF, 1'b1);
        drain_block();

        // A pair that no longer fits, then a single byte that no longer fits.
        write_reg(REG_OUT_LIMIT, 16'd3);
        queue_text("a\n", 1'b1);
        queue_text("xyz", 1'b1);
        drain_block();

        write_reg(REG_OUT_LIMIT, 16'd0);
        queue_text("q", 1'b1);
        drain_block();

        // Every escape letter, an unmapped one and a trailing lone backslash.
        write_reg(REG_DIRECTION, 16'(DIR_UNESCAPE));
        write_reg(REG_OUT_LIMIT, 16'hFFFF);
        queue_text("\\n\\c\\z\\y\\q\\", 1'b1);
        drain_block();

        // Mode changes in the middle of one string share its state.
        write_reg(REG_DIRECTION, 16'(DIR_ESCAPE));
        write_reg(REG_OUT_LIMIT, 16'd2);
        queue_text("ab", 1'b0);
        drain_block();
        write_reg(REG_DIRECTION, 16'(DIR_UNESCAPE));
        queue_text("\\", 1'b0);
        drain_block();
        write_reg(REG_DIRECTION, 16'(DIR_ESCAPE));
        queue_text("q", 1'b0);
        drain_block();
        write_reg(REG_DIRECTION, 16'(DIR_UNESCAPE));
        queue_text("n", 1'b1);
        drain_block();

        while (random_items < RANDOM_ITEMS) begin
            dir = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 6))
                0:       limit = 16'hFFFF;
                1:       limit = 16'($urandom);
                2:       limit = 16'd0;
                default: limit = 16'($urandom_range(1, 24));
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_DIRECTION, 16'(dir));
                write_reg(REG_OUT_LIMIT, limit);
            end else begin
                write_reg(REG_OUT_LIMIT, limit);
                write_reg(REG_DIRECTION, 16'(dir));
            end
            in_mode  = $urandom_range(0, 2);
            out_mode = $urandom_range(0, 2);
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(1, 10);
                // Now and then a phase leaves its last string open.
                close = !(queued + len >= PHASE_ITEMS && $urandom_range(0, 3) == 0);
                queue_random_string(len, dir, close);
                queued += len;
            end
            random_items += queued;
            drain_block();
        end

        $display("Sent %0d bytes in both directions; %0d results checked, %0d strings closed",
                 items_accepted, results_checked, strings_closed);
        $display("of which %0d were truncated; %0d failures", strings_trunc, fail_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- backslash_escape_codec.f -----
src/bec_pkg.sv
src/bec_front.sv
src/bec_queue.sv
src/bec_back.sv
src/backslash_escape_codec.sv
bench/backslash_escape_codec_tb.sv
